// ===== hdl/mmp_pkg.sv =====
`default_nettype none

package mmp_pkg;

   localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
   localparam logic [3:0] TYPE_PROGRAM     = 4'hC;
   localparam logic [3:0] TYPE_PRESSURE    = 4'hD;

   localparam logic REG_RECEIVE_ENABLED = 1'b0;

   typedef enum logic [1:0] {
      KIND_CHANNEL,
      KIND_SYSTEM,
      KIND_SYSEX,
      KIND_OVERFLOW
   } kind_type;

   typedef struct packed {
      logic [7:0] midi_byte;
      logic       packet_end;
   } req_payload_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] status_byte;
      logic [7:0] first_data;
      logic [7:0] second_data;
      logic [7:0] sysex_data;
      logic       run_last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SECOND,
      ST_SYSEX,
      ST_READ,
      ST_SEND,
      ST_CLOSE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_CHAN_NOW,
      EMIT_CHAN_FIRST,
      EMIT_CHAN_SECOND,
      EMIT_SYSTEM,
      EMIT_OVERFLOW,
      EMIT_SX_DATA,
      EMIT_SX_END
   } emit_type;

   typedef struct packed {
      logic     load_status;
      logic     load_first;
      logic     store_first;
      logic     store_byte;
      logic     set_ovf;
      logic     clear_sysex;
      logic     ptr_clear;
      logic     ptr_inc;
      logic     read_en;
      emit_type emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic packet_end;
      logic byte_is_start;
      logic byte_is_end;
      logic byte_is_system;
      logic byte_is_status;
      logic held_two_data;
      logic count_full;
      logic overflowed;
      logic last_entry;
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== hdl/midi_message_parser.sv =====
`default_nettype none

// MIDI message parser. Raw MIDI bytes come in on the req_ channel, each
// flagged when it ends its packet, and parsed messages leave on the rsp_
// channel. Channel messages, single system bytes and the overflow marker
// each give one result; a completed sysex run is released byte by byte from
// the internal store, with run_last on the closing 0xF7. An ordinary byte can
// be followed by the next in the following cycle as long as results are
// taken. The 0xF7 that closes a sysex run blocks the input while the run
// drains: each stored byte (0xF0 included) passes a read state and a send
// state, because the store has one registered read port, and a close state
// then sends the closing 0xF7. Receive is off after reset: register 0 bit 0
// must be set first, and while it is clear every byte is dropped and any
// partial message lost.

module midi_message_parser
   import mmp_pkg::*;
#(
   parameter int SYSEX_DEPTH = 63
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [2:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic            enabled_ff;
   logic            reg_hit;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == REG_RECEIVE_ENABLED);

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (psel && penable && pwrite && reg_hit) begin
         enabled_ff <= pwdata[0];
      end
   end

   assign prdata = reg_hit ? {31'b0, enabled_ff} : '0;

   mmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .enabled   (enabled_ff),
      .status    (status),
      .cmd       (cmd)
   );

   mmp_datapath #(
      .SYSEX_DEPTH (SYSEX_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// ===== hdl/mmp_ctrl.sv =====
`default_nettype none

module mmp_ctrl
   import mmp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            enabled,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           in_parse;
   logic           accept;

   assign in_parse = (state_ff == ST_IDLE) || (state_ff == ST_FIRST) ||
                     (state_ff == ST_SECOND) || (state_ff == ST_SYSEX);
   assign req_ready = in_parse && status.out_free;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (accept && !enabled) begin
         state_in = ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (status.byte_is_start) begin
                     if (!status.packet_end) begin
                        state_in = ST_SYSEX;
                     end
                  end else if (!status.byte_is_system && status.byte_is_status &&
                               !status.packet_end) begin
                     state_in = ST_FIRST;
                  end
               end
            end
            ST_FIRST: begin
               if (accept) begin
                  if (!status.held_two_data || status.packet_end) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_SECOND;
                  end
               end
            end
            ST_SECOND: begin
               if (accept) begin
                  state_in = ST_IDLE;
               end
            end
            ST_SYSEX: begin
               if (accept) begin
                  if (status.byte_is_end) begin
                     state_in = status.overflowed ? ST_IDLE : ST_READ;
                  end else if (status.packet_end) begin
                     state_in = ST_IDLE;
                  end
               end
            end
            ST_READ: begin
               state_in = ST_SEND;
            end
            ST_SEND: begin
               if (status.out_free) begin
                  state_in = status.last_entry ? ST_CLOSE : ST_READ;
               end
            end
            ST_CLOSE: begin
               if (status.out_free) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.emit = EMIT_NONE;
      if (accept && !enabled) begin
         cmd.clear_sysex = 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (status.byte_is_start) begin
                     cmd.store_first = !status.packet_end;
                  end else if (status.byte_is_system) begin
                     cmd.emit = EMIT_SYSTEM;
                  end else if (status.byte_is_status) begin
                     if (status.packet_end) begin
                        cmd.emit = EMIT_CHAN_NOW;
                     end else begin
                        cmd.load_status = 1'b1;
                     end
                  end
               end
            end
            ST_FIRST: begin
               if (accept) begin
                  if (!status.held_two_data || status.packet_end) begin
                     cmd.emit = EMIT_CHAN_FIRST;
                  end else begin
                     cmd.load_first = 1'b1;
                  end
               end
            end
            ST_SECOND: begin
               if (accept) begin
                  cmd.emit = EMIT_CHAN_SECOND;
               end
            end
            ST_SYSEX: begin
               if (accept) begin
                  if (status.byte_is_end) begin
                     if (status.overflowed) begin
                        cmd.emit        = EMIT_OVERFLOW;
                        cmd.clear_sysex = 1'b1;
                     end else begin
                        cmd.ptr_clear = 1'b1;
                     end
                  end else if (status.packet_end) begin
                     cmd.clear_sysex = 1'b1;
                  end else if (!status.count_full) begin
                     cmd.store_byte = 1'b1;
                  end else begin
                     cmd.set_ovf = 1'b1;
                  end
               end
            end
            ST_READ: begin
               cmd.read_en = 1'b1;
            end
            ST_SEND: begin
               if (status.out_free) begin
                  cmd.emit    = EMIT_SX_DATA;
                  cmd.ptr_inc = 1'b1;
               end
            end
            ST_CLOSE: begin
               if (status.out_free) begin
                  cmd.emit        = EMIT_SX_END;
                  cmd.clear_sysex = 1'b1;
               end
            end
            default: begin
               cmd.clear_sysex = 1'b1;
            end
         endcase
      end
   end

   // The store is only read while the input side is closed.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_SEND || state_ff == ST_CLOSE) |-> !req_ready)
      else $error("input accepted during sysex release");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_SEND)
      else $error("store read not followed by send");

   assert property (@(posedge clock) disable iff (reset)
      (accept && !enabled) |=> state_ff == ST_IDLE)
      else $error("disabled transfer did not return parser to idle");

endmodule

`default_nettype wire

// ===== hdl/mmp_datapath.sv =====
`default_nettype none

module mmp_datapath
   import mmp_pkg::*;
#(
   parameter int SYSEX_DEPTH = 63
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_data,
   input  wire logic            rsp_ready,
   output logic                 rsp_valid,
   output rsp_payload_type      rsp_data,
   input  wire ctrl_cmd_type    cmd,
   output ctrl_status_type      status
);

   localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
   localparam int CW = $clog2(SYSEX_DEPTH + 1);

   logic [7:0]      sysex_store_ff [SYSEX_DEPTH];
   logic [7:0]      rd_data_ff;
   logic [7:0]      held_status_ff;
   logic [7:0]      held_first_ff;
   logic [CW-1:0]   count_ff;
   logic            overflowed_ff;
   logic [AW-1:0]   ptr_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [7:0]      wr_data;
   logic [7:0]      in_byte;
   logic [3:0]      held_type;

   assign in_byte   = req_data.midi_byte;
   assign held_type = held_status_ff[7:4];

   assign status.packet_end     = req_data.packet_end;
   assign status.byte_is_start  = (in_byte == BYTE_SYSEX_START);
   assign status.byte_is_end    = (in_byte == BYTE_SYSEX_END);
   assign status.byte_is_system = (in_byte > BYTE_SYSEX_START);
   assign status.byte_is_status = in_byte[7];
   assign status.held_two_data  = (held_type != TYPE_PROGRAM) &&
                                  (held_type != TYPE_PRESSURE);
   assign status.count_full     = (count_ff == CW'(SYSEX_DEPTH));
   assign status.overflowed     = overflowed_ff;
   assign status.last_entry     = (CW'(ptr_ff) + CW'(1)) == count_ff;
   assign status.out_free       = !rsp_valid_ff || rsp_ready;

   assign wr_en   = cmd.store_first || cmd.store_byte;
   assign wr_addr = cmd.store_first ? '0 : count_ff[AW-1:0];
   assign wr_data = cmd.store_first ? BYTE_SYSEX_START : in_byte;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sysex_store_ff[wr_addr] <= wr_data;
      end
      if (cmd.read_en) begin
         rd_data_ff <= sysex_store_ff[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_status) begin
         held_status_ff <= in_byte;
      end
      if (cmd.load_first) begin
         held_first_ff <= in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         overflowed_ff <= 1'b0;
         ptr_ff        <= '0;
      end else begin
         if (cmd.clear_sysex) begin
            count_ff      <= '0;
            overflowed_ff <= 1'b0;
         end else if (cmd.store_first) begin
            count_ff      <= CW'(1);
            overflowed_ff <= 1'b0;
         end else if (cmd.store_byte) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.set_ovf) begin
            overflowed_ff <= 1'b1;
         end
         if (cmd.ptr_clear) begin
            ptr_ff <= '0;
         end else if (cmd.ptr_inc) begin
            ptr_ff <= ptr_ff + AW'(1);
         end
      end
   end

   always_comb begin
      rsp_data_in          = '0;
      rsp_data_in.kind     = KIND_CHANNEL;
      rsp_data_in.run_last = 1'b1;
      case (cmd.emit)
         EMIT_CHAN_NOW: begin
            rsp_data_in.status_byte = in_byte;
         end
         EMIT_CHAN_FIRST: begin
            rsp_data_in.status_byte = held_status_ff;
            rsp_data_in.first_data  = in_byte;
         end
         EMIT_CHAN_SECOND: begin
            rsp_data_in.status_byte = held_status_ff;
            rsp_data_in.first_data  = held_first_ff;
            rsp_data_in.second_data = in_byte;
         end
         EMIT_SYSTEM: begin
            rsp_data_in.kind        = KIND_SYSTEM;
            rsp_data_in.status_byte = in_byte;
         end
         EMIT_OVERFLOW: begin
            rsp_data_in.kind = KIND_OVERFLOW;
         end
         EMIT_SX_DATA: begin
            rsp_data_in.kind       = KIND_SYSEX;
            rsp_data_in.sysex_data = rd_data_ff;
            rsp_data_in.run_last   = 1'b0;
         end
         EMIT_SX_END: begin
            rsp_data_in.kind       = KIND_SYSEX;
            rsp_data_in.sysex_data = BYTE_SYSEX_END;
         end
         default: begin
            rsp_data_in.run_last = 1'b1;
         end
      endcase
   end

   // The output register is refilled in the same cycle its result transfers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EMIT_NONE) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SYSEX_DEPTH))
      else $error("sysex count beyond store depth");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != EMIT_NONE) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites one not yet transferred");

   assert property (@(posedge clock) disable iff (reset)
      cmd.store_byte |-> (count_ff != '0) && !status.count_full)
      else $error("sysex byte stored outside an open run");

endmodule

`default_nettype wire

// ===== verif/midi_message_parser_tb.sv =====
module midi_message_parser_tb;
   import mmp_pkg::*;

   localparam int SYSEX_DEPTH = 63;
   localparam logic [7:0] STATUS_MIN = 8'h80;
   localparam logic [2:0] RX_EN_ADDR = {REG_RECEIVE_ENABLED, 2'b00};
   // Settle time covers the worst drain of a sysex run: a read and a send per stored byte plus the close.
   localparam int SETTLE_CYCLES = 2 * SYSEX_DEPTH + 16;
   localparam int QUIET_LIMIT = 4000;
   localparam int PLAN_ROWS = 25;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_SILENT,
      ROW_ONE
   } row_check_type;

   typedef struct packed {
      logic [7:0]      midi_byte;
      logic            packet_end;
      row_check_type   check;
      rsp_payload_type msg;
   } step_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            psel = 1'b0;
   logic            penable = 1'b0;
   logic            pwrite = 1'b0;
   logic [2:0]      paddr = '0;
   logic [31:0]     pwdata = '0;
   logic [31:0]     prdata;
   logic            pready;

   // Parser state as the block should hold it.
   logic            rx_enabled = 1'b0;
   ctrl_state_type  parse_state = ST_IDLE;
   logic [7:0]      held_status = '0;
   logic [7:0]      held_first = '0;
   logic [7:0]      sx_buf [SYSEX_DEPTH];
   int              sx_count = 0;
   logic            sx_overflow = 1'b0;

   rsp_payload_type expected_msgs [$];
   step_row_type    plan [PLAN_ROWS];
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              bytes_sent = 0;
   int              mismatches = 0;
   int              quiet_cycles = 0;

   midi_message_parser #(.SYSEX_DEPTH(SYSEX_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_payload_type msg_of(kind_type k, logic [7:0] st, logic [7:0] d1,
                                              logic [7:0] d2, logic [7:0] sx, logic last);
      rsp_payload_type m;
      m.kind = k;
      m.status_byte = st;
      m.first_data = d1;
      m.second_data = d2;
      m.sysex_data = sx;
      m.run_last = last;
      return m;
   endfunction

   function automatic rsp_payload_type chan(logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
      return msg_of(KIND_CHANNEL, st, d1, d2, 8'h00, 1'b1);
   endfunction

   function automatic rsp_payload_type sys(logic [7:0] st);
      return msg_of(KIND_SYSTEM, st, 8'h00, 8'h00, 8'h00, 1'b1);
   endfunction

   function automatic step_row_type step(logic [7:0] b, logic pend, row_check_type c,
                                         rsp_payload_type m);
      step_row_type s;
      s.midi_byte = b;
      s.packet_end = pend;
      s.check = c;
      s.msg = m;
      return s;
   endfunction

   function automatic logic [7:0] rand_data();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   // Advances the parser by one byte and, when keep is set, queues the messages that it releases.
   task automatic parse_byte(input logic [7:0] b, input logic pend, input bit keep);
      rsp_payload_type produced [$];
      int i;
      if (!rx_enabled) begin
         parse_state = ST_IDLE;
         sx_count = 0;
         sx_overflow = 1'b0;
      end else begin
         case (parse_state)
            ST_FIRST: begin
               if (held_status[7:4] == TYPE_PROGRAM || held_status[7:4] == TYPE_PRESSURE
                   || pend) begin
                  produced = {produced, chan(held_status, b, 8'h00)};
                  parse_state = ST_IDLE;
               end else begin
                  held_first = b;
                  parse_state = ST_SECOND;
               end
            end
            ST_SECOND: begin
               produced = {produced, chan(held_status, held_first, b)};
               parse_state = ST_IDLE;
            end
            ST_SYSEX: begin
               if (b == BYTE_SYSEX_END) begin
                  if (sx_overflow) begin
                     produced = {produced,
                                 msg_of(KIND_OVERFLOW, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1)};
                  end else begin
                     for (i = 0; i < sx_count; i++)
                        produced = {produced,
                                    msg_of(KIND_SYSEX, 8'h00, 8'h00, 8'h00, sx_buf[i], 1'b0)};
                     produced = {produced,
                                 msg_of(KIND_SYSEX, 8'h00, 8'h00, 8'h00, BYTE_SYSEX_END,
                                        1'b1)};
                  end
                  parse_state = ST_IDLE;
                  sx_count = 0;
                  sx_overflow = 1'b0;
               end else if (pend) begin
                  // A run cut off by the end of its packet is thrown away.
                  parse_state = ST_IDLE;
                  sx_count = 0;
                  sx_overflow = 1'b0;
               end else if (sx_count < SYSEX_DEPTH) begin
                  sx_buf[sx_count] = b;
                  sx_count++;
               end else begin
                  sx_overflow = 1'b1;
               end
            end
            default: begin
               if (b == BYTE_SYSEX_START) begin
                  if (!pend) begin
                     sx_buf[0] = b;
                     sx_count = 1;
                     sx_overflow = 1'b0;
                     parse_state = ST_SYSEX;
                  end
               end else if (b > BYTE_SYSEX_START) begin
                  produced = {produced, sys(b)};
               end else if (b >= STATUS_MIN) begin
                  if (pend) begin
                     produced = {produced, chan(b, 8'h00, 8'h00)};
                  end else begin
                     held_status = b;
                     parse_state = ST_FIRST;
                  end
               end
            end
         endcase
      end
      if (keep) begin
         expected_msgs = {expected_msgs, produced};
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic pend, input bit keep);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{midi_byte: b, packet_end: pend};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      parse_byte(b, pend, keep);
   endtask

   task automatic send_sysex(input int n_data, input bit cut);
      logic [7:0] b;
      send_byte(BYTE_SYSEX_START, cut && n_data == 0, 1'b1);
      for (int i = 0; i < n_data; i++) begin
         b = rand_data();
         if (b == BYTE_SYSEX_END) b = 8'h5A;
         send_byte(b, cut && i == n_data - 1, 1'b1);
      end
      if (!cut) send_byte(BYTE_SYSEX_END, 1'($urandom_range(0, 1)), 1'b1);
   endtask

   // Waits until every expected message has come back and the block has gone quiet.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_msgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_receive_enabled(input logic on);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= RX_EN_ADDR;
      pwdata <= {31'b0, on};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rx_enabled = on;
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[0] !== on) begin
         $error("receive_enabled readback: expected %0h, got %0h", on, prdata[0]);
         mismatches++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic random_traffic(input int budget);
      int start;
      int pick;
      int cut;
      logic [7:0] st;
      logic [7:0] d;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            cut = $urandom_range(0, 99);
            if (cut < 12) begin
               send_byte(st, 1'b1, 1'b1);
            end else begin
               send_byte(st, 1'b0, 1'b1);
               d = rand_data();
               if (st[7:4] == TYPE_PROGRAM || st[7:4] == TYPE_PRESSURE) begin
                  send_byte(d, 1'($urandom_range(0, 1)), 1'b1);
               end else if (cut < 24) begin
                  send_byte(d, 1'b1, 1'b1);
               end else begin
                  send_byte(d, 1'b0, 1'b1);
                  send_byte(rand_data(), 1'($urandom_range(0, 1)), 1'b1);
               end
            end
         end else if (pick < 55) begin
            send_byte(8'($urandom_range(8'hF1, 8'hFF)), 1'($urandom_range(0, 1)), 1'b1);
         end else if (pick < 80) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) cut = $urandom_range(0, 8);
            else if (pick < 90) cut = $urandom_range(9, 40);
            else cut = $urandom_range(SYSEX_DEPTH - 8, SYSEX_DEPTH + 7);
            send_sysex(cut, $urandom_range(0, 99) < 15);
         end else begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         end
      end
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_msgs.size() == 0) begin
            $error("unexpected result transfer: %h", rsp_data);
            mismatches++;
         end else begin
            want = expected_msgs.pop_front();
            if (rsp_data.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_data.kind);
               mismatches++;
            end
            if (rsp_data.status_byte !== want.status_byte) begin
               $error("status_byte: expected %h, got %h", want.status_byte,
                      rsp_data.status_byte);
               mismatches++;
            end
            if (rsp_data.first_data !== want.first_data) begin
               $error("first_data: expected %h, got %h", want.first_data, rsp_data.first_data);
               mismatches++;
            end
            if (rsp_data.second_data !== want.second_data) begin
               $error("second_data: expected %h, got %h", want.second_data,
                      rsp_data.second_data);
               mismatches++;
            end
            if (rsp_data.sysex_data !== want.sysex_data) begin
               $error("sysex_data: expected %h, got %h", want.sysex_data, rsp_data.sysex_data);
               mismatches++;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $error("run_last: expected %0d, got %0d", want.run_last, rsp_data.run_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("midi_message_parser_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int idle_of [5];
      int stall_of [5];
      logic en_of [5];
      int budget_of [5];
      idle_of = '{0, 65, 0, 0, 31};
      stall_of = '{0, 0, 65, 65, 31};
      en_of = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      budget_of = '{80, 80, 30, 80, 80};

      plan = '{
         step(8'h05, 1'b0, ROW_SILENT, '0),
         step(8'h90, 1'b0, ROW_SILENT, '0),
         step(8'h3C, 1'b0, ROW_SILENT, '0),
         step(8'h7F, 1'b1, ROW_ONE, chan(8'h90, 8'h3C, 8'h7F)),
         step(8'hC5, 1'b0, ROW_SILENT, '0),
         step(8'hFF, 1'b0, ROW_ONE, chan(8'hC5, 8'hFF, 8'h00)),
         step(8'hD0, 1'b0, ROW_SILENT, '0),
         step(8'h00, 1'b1, ROW_ONE, chan(8'hD0, 8'h00, 8'h00)),
         step(8'h80, 1'b1, ROW_ONE, chan(8'h80, 8'h00, 8'h00)),
         step(8'hEF, 1'b0, ROW_SILENT, '0),
         step(8'h12, 1'b1, ROW_ONE, chan(8'hEF, 8'h12, 8'h00)),
         step(8'hF1, 1'b1, ROW_ONE, sys(8'hF1)),
         step(8'hFF, 1'b0, ROW_ONE, sys(8'hFF)),
         step(8'hF7, 1'b0, ROW_ONE, sys(8'hF7)),
         step(8'hF0, 1'b0, ROW_SILENT, '0),
         step(8'h7E, 1'b0, ROW_SILENT, '0),
         step(8'h00, 1'b0, ROW_SILENT, '0),
         step(8'hF7, 1'b1, ROW_PREDICT, '0),
         step(8'hF0, 1'b0, ROW_SILENT, '0),
         step(8'h01, 1'b1, ROW_SILENT, '0),
         step(8'hF0, 1'b1, ROW_SILENT, '0),
         step(8'hB0, 1'b0, ROW_SILENT, '0),
         step(8'h80, 1'b0, ROW_SILENT, '0),
         step(8'hF0, 1'b0, ROW_ONE, chan(8'hB0, 8'h80, 8'hF0)),
         step(8'hAA, 1'b0, ROW_SILENT, '0)
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_receive_enabled(1'b1);
      // The longest run that still fits the store, then one byte more.
      send_sysex(SYSEX_DEPTH - 1, 1'b0);
      send_sysex(SYSEX_DEPTH, 1'b0);
      foreach (plan[r]) begin
         send_byte(plan[r].midi_byte, plan[r].packet_end, plan[r].check == ROW_PREDICT);
         if (plan[r].check == ROW_ONE) expected_msgs = {expected_msgs, plan[r].msg};
      end
      // The last row leaves a status pending; a byte taken while disabled drops it.
      wait_drained();
      set_receive_enabled(1'b0);
      send_byte(8'h3C, 1'b0, 1'b1);

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         send_idle_pct = idle_of[p];
         stall_pct = stall_of[p];
         set_receive_enabled(en_of[p]);
         random_traffic(budget_of[p]);
      end
      stall_pct = 0;
      wait_drained();

      if (mismatches == 0) begin
         $display("midi_message_parser_tb OK");
      end else begin
         $display("midi_message_parser_tb NOT OK");
      end
      $finish;
   end

endmodule
